>>> hw/rtl/rsp_pkg.sv
package rsp_pkg;

    // Image store geometry
    localparam int IMAGE_BYTES = 65536;
    localparam int IMG_AW      = $clog2(IMAGE_BYTES);

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic REG_IDX_RELOC_BASE = 1'b0;
    localparam logic [31:0] RELOC_BASE_RESET = 32'h0000_1000;

    // Transaction kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_STREAM = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_PATCHED      = 3'd1;
    localparam logic [2:0] ST_SKIPPED      = 3'd2;
    localparam logic [2:0] ST_FINISHED     = 3'd3;
    localparam logic [2:0] ST_BAD_CODE     = 3'd4;
    localparam logic [2:0] ST_TRUNCATED    = 3'd5;
    localparam logic [2:0] ST_OUT_OF_RANGE = 3'd6;
    localparam logic [2:0] ST_IGNORED      = 3'd7;

    // Stream codes
    localparam logic [7:0] CODE_END  = 8'h00;
    localparam logic [7:0] CODE_SKIP = 8'h01;
    localparam logic [31:0] SKIP_DISTANCE = 32'd254;

    typedef logic [IMG_AW-1:0] img_addr_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  status;
        logic [31:0] patch_offset;
    } out_item_t;

    typedef struct packed {
        logic      en;
        logic      we;
        img_addr_t addr;
        logic [7:0] wdata;
    } ram_req_t;

endpackage

>>> hw/rtl/relocation_stream_patcher.sv
// Path to out_valid: EXEC, FINISH for an image write or a stream byte that needs no patch;
// EXEC, RDWAIT, FINISH for an image read; EXEC, CHECK (range check), FINISH for a longword
// past the store; EXEC, CHECK, PATCH (byte-serial read/add/write via one image port and one
// 8-bit adder), FINISH for a patch. One transaction at a time; in_stall is low only while idle.
// Reset (rst_n, async, active low): parser back to header collection, offset 0, reloc_base
// 0x1000, no result pending. Image contents are undefined until written.
module relocation_stream_patcher
    import rsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input transactions
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    // result transactions
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_CHECK,
        S_PATCH,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RELOC,
        PH_CLOSED
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] base_reg, base_next;
    in_item_t    item_reg, item_next;
    logic [7:0]  res_rdata_reg, res_rdata_next;
    logic [2:0]  res_status_reg, res_status_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;

    ram_req_t    top_req, patch_req, ram_req;
    logic [7:0]  ram_rdata;
    logic        patch_start;
    logic        patch_done;

    logic        addr_in_range;
    logic        patch_in_range;
    logic [2:0]  hdr_cnt_inc;
    logic [31:0] hdr_offset;
    logic        cfg_write;

    // ------------------------------------------------------------------
    // Configuration: one register, byte lanes ignored, always ready
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_IDX_RELOC_BASE) ? base_reg : '0;

    // ------------------------------------------------------------------
    // Image store; the patch sequencer owns the port while it runs
    // ------------------------------------------------------------------
    assign ram_req = (state_reg == S_PATCH) ? patch_req : top_req;

    rsp_ram #(
        .WIDTH (8),
        .DEPTH (IMAGE_BYTES)
    ) u_image (
        .clk   (clk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    rsp_patch u_patch (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (patch_start),
        .offset    (IMG_AW'(offset_reg)),
        .base      (base_reg),
        .ram_rdata (ram_rdata),
        .ram_req   (patch_req),
        .done      (patch_done)
    );

    // ------------------------------------------------------------------
    // Decode helpers
    // ------------------------------------------------------------------
    assign addr_in_range  = ({(IMG_AW + 2)'(item_reg.address)} < (IMG_AW + 2)'(IMAGE_BYTES));
    // all four bytes of the longword must fall inside the store
    assign patch_in_range = (({1'b0, offset_reg} + 33'd4) <= 33'(IMAGE_BYTES));
    assign hdr_cnt_inc    = hdr_cnt_reg + 3'd1;
    // first header byte loads the offset, later ones shift in big-endian
    assign hdr_offset     = (hdr_cnt_reg == 3'd0) ? {24'd0, item_reg.data_byte}
                                                  : {offset_reg[23:0], item_reg.data_byte};

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        offset_next     = offset_reg;
        base_next       = base_reg;
        item_next       = item_reg;
        res_rdata_next  = res_rdata_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        top_req         = '0;
        patch_start     = 1'b0;

        if (cfg_write && (paddr[2] == REG_IDX_RELOC_BASE))
        begin
            base_next = pwdata;
        end

        // drop the result once the far side takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_rdata_next = 8'd0;
                state_next     = S_FINISH;
                unique case (item_reg.kind)
                    KIND_WRITE:
                    begin
                        if (addr_in_range)
                        begin
                            top_req.en      = 1'b1;
                            top_req.we      = 1'b1;
                            top_req.addr    = IMG_AW'(item_reg.address);
                            top_req.wdata   = item_reg.data_byte;
                            res_status_next = ST_OK;
                        end
                        else
                        begin
                            res_status_next = ST_IGNORED;
                        end
                    end

                    KIND_READ:
                    begin
                        if (addr_in_range)
                        begin
                            top_req.en      = 1'b1;
                            top_req.addr    = IMG_AW'(item_reg.address);
                            res_status_next = ST_OK;
                            state_next      = S_RDWAIT;
                        end
                        else
                        begin
                            res_status_next = ST_IGNORED;
                        end
                    end

                    KIND_STREAM:
                    begin
                        priority if (phase_reg == PH_HEADER)
                        begin
                            offset_next  = hdr_offset;
                            hdr_cnt_next = hdr_cnt_inc;
                            priority if (hdr_cnt_inc < 3'd4)
                            begin
                                res_status_next = ST_OK;
                            end
                            else if (hdr_offset == 32'd0)
                            begin
                                // zero start offset: nothing to relocate
                                phase_next      = PH_CLOSED;
                                res_status_next = ST_FINISHED;
                            end
                            else
                            begin
                                phase_next = PH_RELOC;
                                state_next = S_CHECK;
                            end
                        end
                        else if (phase_reg == PH_RELOC)
                        begin
                            priority if (item_reg.data_byte == CODE_END)
                            begin
                                phase_next      = PH_CLOSED;
                                res_status_next = ST_FINISHED;
                            end
                            else if (item_reg.data_byte == CODE_SKIP)
                            begin
                                offset_next     = offset_reg + SKIP_DISTANCE;
                                res_status_next = ST_SKIPPED;
                            end
                            else if (!item_reg.data_byte[0])
                            begin
                                offset_next = offset_reg + {24'd0, item_reg.data_byte};
                                state_next  = S_CHECK;
                            end
                            else
                            begin
                                phase_next      = PH_CLOSED;
                                res_status_next = ST_BAD_CODE;
                            end
                        end
                        else
                        begin
                            res_status_next = ST_IGNORED;
                        end
                    end

                    KIND_END:
                    begin
                        priority if (phase_reg == PH_HEADER)
                        begin
                            res_status_next = ST_FINISHED;
                        end
                        else if (phase_reg == PH_RELOC)
                        begin
                            res_status_next = ST_TRUNCATED;
                        end
                        else
                        begin
                            res_status_next = ST_IGNORED;
                        end
                        // re-arm; the offset stays until the next header byte
                        phase_next   = PH_HEADER;
                        hdr_cnt_next = 3'd0;
                    end
                endcase
            end

            S_RDWAIT:
            begin
                res_rdata_next = ram_rdata;
                state_next     = S_FINISH;
            end

            S_CHECK:
            begin
                if (patch_in_range)
                begin
                    patch_start = 1'b1;
                    state_next  = S_PATCH;
                end
                else
                begin
                    res_status_next = ST_OUT_OF_RANGE;
                    state_next      = S_FINISH;
                end
            end

            S_PATCH:
            begin
                if (patch_done)
                begin
                    res_status_next = ST_PATCHED;
                    state_next      = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_item_next.read_data    = res_rdata_reg;
                    out_item_next.status       = res_status_reg;
                    out_item_next.patch_offset = offset_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= 3'd0;
            offset_reg     <= 32'd0;
            base_reg       <= RELOC_BASE_RESET;
            item_reg       <= '0;
            res_rdata_reg  <= 8'd0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            offset_reg     <= offset_next;
            base_reg       <= base_next;
            item_reg       <= item_next;
            res_rdata_reg  <= res_rdata_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_item_reg   <= out_item_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_header_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg <= 3'd4)
        else $error("header byte count ran past four");

    a_phase_needs_full_header: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HEADER) |-> (hdr_cnt_reg == 3'd4))
        else $error("parser left header collection without a full header");

    a_patch_only_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        patch_start |-> patch_in_range)
        else $error("patch started on a longword past the store");

    a_single_transaction: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transaction accepted while one is in flight");

    a_patch_done_in_patch: assert property (@(posedge clk) disable iff (!rst_n)
        patch_done |-> (state_reg == S_PATCH))
        else $error("patch sequencer finished outside a patch");

endmodule

>>> hw/rtl/rsp_ram.sv
module rsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

>>> hw/rtl/rsp_patch.sv
module rsp_patch
    import rsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  img_addr_t  offset,
    input  logic [31:0] base,
    input  logic [7:0] ram_rdata,
    output ram_req_t   ram_req,
    output logic       done
);

    typedef enum logic [1:0] {
        P_IDLE,
        P_READ,
        P_WRITE
    } pstate_t;

    pstate_t    state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       carry_reg, carry_next;
    img_addr_t  off_reg, off_next;

    logic [7:0] base_byte;
    logic [8:0] sum;

    // Byte idx holds word bits 8*(3-idx); walk from the low byte up so the carry ripples
    assign base_byte = base[{~idx_reg, 3'b000} +: 8];
    assign sum       = {1'b0, ram_rdata} + {1'b0, base_byte} + {8'd0, carry_reg};

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        carry_next = carry_reg;
        off_next   = off_reg;
        ram_req    = '0;
        done       = 1'b0;
        unique case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    off_next   = offset;
                    idx_next   = 2'd3;
                    carry_next = 1'b0;
                    state_next = P_READ;
                end
            end
            P_READ:
            begin
                ram_req.en   = 1'b1;
                ram_req.addr = off_reg + IMG_AW'(idx_reg);
                state_next   = P_WRITE;
            end
            P_WRITE:
            begin
                ram_req.en    = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.addr  = off_reg + IMG_AW'(idx_reg);
                ram_req.wdata = sum[7:0];
                carry_next    = sum[8];
                if (idx_reg == 2'd0)
                begin
                    done       = 1'b1;
                    state_next = P_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg - 2'd1;
                    state_next = P_READ;
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            idx_reg   <= 2'd0;
            carry_reg <= 1'b0;
            off_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            carry_reg <= carry_next;
            off_reg   <= off_next;
        end
    end

endmodule

>>> tb/sv/rsp_checker.sv
`timescale 1ns / 100ps

module rsp_checker
    import rsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  in_item_t          in_item,
    input  logic              out_valid,
    input  logic              out_stall,
    input  out_item_t         out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);

    localparam logic [CFG_AW-1:0] ADDR_RELOC_BASE = CFG_AW'(4 * REG_IDX_RELOC_BASE);

    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_RELOC,
        PARSE_CLOSED
    } parse_phase_e;

    logic [7:0]   image_copy [0:IMAGE_BYTES-1];
    logic [31:0]  offset_q;
    logic [2:0]   hdr_seen;
    parse_phase_e phase;
    logic [31:0]  base;
    out_item_t    expected_q [$];
    int           errors;

    // Add the base to the big-endian longword at off, if it fits in the store.
    function automatic logic [2:0] relocate_at(input logic [31:0] off);
        logic [31:0]       word;
        logic [IMG_AW-1:0] a;
        if ({1'b0, off} + 33'd4 > 33'(IMAGE_BYTES))
            return ST_OUT_OF_RANGE;
        a = off[IMG_AW-1:0];
        word = {image_copy[a], image_copy[a + 1], image_copy[a + 2], image_copy[a + 3]} + base;
        image_copy[a]     = word[31:24];
        image_copy[a + 1] = word[23:16];
        image_copy[a + 2] = word[15:8];
        image_copy[a + 3] = word[7:0];
        return ST_PATCHED;
    endfunction

    function automatic logic [2:0] decode_stream_byte(input logic [7:0] b);
        if (phase == PARSE_HEADER) begin
            offset_q = (hdr_seen == 3'd0) ? {24'd0, b} : {offset_q[23:0], b};
            hdr_seen = hdr_seen + 3'd1;
            if (hdr_seen < 3'd4)
                return ST_OK;
            if (offset_q == 32'd0) begin
                phase = PARSE_CLOSED;
                return ST_FINISHED;
            end
            phase = PARSE_RELOC;
            return relocate_at(offset_q);
        end
        if (phase != PARSE_RELOC)
            return ST_IGNORED;
        if (b == CODE_END) begin
            phase = PARSE_CLOSED;
            return ST_FINISHED;
        end
        if (b == CODE_SKIP) begin
            offset_q = offset_q + SKIP_DISTANCE;
            return ST_SKIPPED;
        end
        if (!b[0]) begin
            offset_q = offset_q + {24'd0, b};
            return relocate_at(offset_q);
        end
        phase = PARSE_CLOSED;
        return ST_BAD_CODE;
    endfunction

    function automatic out_item_t predict_result(input in_item_t it);
        out_item_t r;
        r = '0;
        case (it.kind)
            KIND_WRITE: begin
                if (32'(it.address) < IMAGE_BYTES) begin
                    image_copy[it.address] = it.data_byte;
                    r.status = ST_OK;
                end else begin
                    r.status = ST_IGNORED;
                end
            end
            KIND_READ: begin
                if (32'(it.address) < IMAGE_BYTES) begin
                    r.read_data = image_copy[it.address];
                    r.status = ST_OK;
                end else begin
                    r.status = ST_IGNORED;
                end
            end
            KIND_STREAM: r.status = decode_stream_byte(it.data_byte);
            default: begin
                case (phase)
                    PARSE_HEADER: r.status = ST_FINISHED;
                    PARSE_RELOC:  r.status = ST_TRUNCATED;
                    default:      r.status = ST_IGNORED;
                endcase
                phase = PARSE_HEADER;
                hdr_seen = 3'd0;
            end
        endcase
        r.patch_offset = offset_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            offset_q = '0;
            hdr_seen = '0;
            phase    = PARSE_HEADER;
            base     = RELOC_BASE_RESET;
            errors   = 0;
            expected_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            // retire the oldest result before queuing a new one
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual %h",
                             $time, out_item);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("read_data", 32'(want.read_data), 32'(out_item.read_data));
                    check_field("status", 32'(want.status), 32'(out_item.status));
                    check_field("patch_offset", want.patch_offset, out_item.patch_offset);
                end
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_RELOC_BASE)
                base = pwdata;
            if (in_valid && !in_stall)
                expected_q.push_back(predict_result(in_item));
            fail_count <= errors;
            pending    <= expected_q.size();
        end
    end

endmodule

>>> tb/sv/tb_relocation_stream_patcher.sv
`timescale 1ns / 100ps

module tb_relocation_stream_patcher;
    import rsp_pkg::*;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int NUM_PHASES      = 5;
    localparam int IDLE_PERCENT    = 7;

    localparam logic [CFG_AW-1:0] ADDR_RELOC_BASE = CFG_AW'(4 * REG_IDX_RELOC_BASE);
    // one word past the only register: nothing lives there
    localparam logic [CFG_AW-1:0] ADDR_UNMAPPED   = ADDR_RELOC_BASE + CFG_AW'(4);

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    in_item_t          in_item  = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_item_t         out_item;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [CFG_AW-1:0] paddr    = '0;
    logic [CFG_DW-1:0] pwdata   = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int item_count  = 0;
    bit calm        = 1'b0;   // suppress all idling on both sides

    // Track which image bytes hold data, so no read (direct or by a patch)
    // ever touches an unwritten byte.
    bit written_map [0:IMAGE_BYTES-1];
    int written_list [$];

    relocation_stream_patcher i_dut (
        .clk,
        .rst_n,
        .in_valid,
        .in_stall,
        .in_item,
        .out_valid,
        .out_stall,
        .out_item,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    rsp_checker i_checker (
        .clk,
        .rst_n,
        .in_valid,
        .in_stall,
        .in_item,
        .out_valid,
        .out_stall,
        .out_item,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .pready,
        .fail_count,
        .pending
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel now and then, independent of out_valid.
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Watchdog: give up if the run stalls far past its expected length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Present one transaction and return at the edge that accepts it. Valid
    // stays high on return, so the caller must present the next transaction
    // or release the channel in the same time step.
    task automatic send_item(input logic [1:0] kind_code, input logic [15:0] addr,
                             input logic [7:0] data, input bit counted);
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_item.kind      <= kind_code;
        in_item.address   <= addr;
        in_item.data_byte <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (counted)
            item_count++;
    endtask

    task automatic put_byte(input logic [15:0] addr, input logic [7:0] data);
        send_item(KIND_WRITE, addr, data, 1'b1);
        if (!written_map[addr]) begin
            written_map[addr] = 1'b1;
            written_list.push_back(int'(addr));
        end
    endtask

    task automatic fetch_byte(input logic [15:0] addr);
        send_item(KIND_READ, addr, 8'($urandom), 1'b1);
    endtask

    // Address bits are don't-care for stream transactions: randomize them.
    task automatic feed(input logic [7:0] b, input bit counted);
        send_item(KIND_STREAM, 16'($urandom), b, counted);
    endtask

    task automatic close_stream(input bit counted);
        send_item(KIND_END, 16'($urandom), 8'($urandom), counted);
    endtask

    function automatic bit fits(input logic [31:0] off);
        return off <= 32'(IMAGE_BYTES - 4);
    endfunction

    // Fill any unwritten byte of the longword at off before it gets patched.
    task automatic cover_patch(input logic [31:0] off);
        logic [15:0] a;
        if (fits(off)) begin
            for (int i = 0; i < 4; i++) begin
                a = off[15:0] + 16'(i);
                if (!written_map[a])
                    put_byte(a, 8'($urandom));
            end
        end
    endtask

    task automatic feed_header(input logic [31:0] off);
        feed(off[31:24], 1'b1);
        feed(off[23:16], 1'b1);
        feed(off[15:8], 1'b1);
        feed(off[7:0], 1'b1);
    endtask

    // After the stream closes: stray bytes and the final end marker are ignored.
    task automatic trailing_noise();
        repeat ($urandom_range(0, 2)) feed(8'($urandom), 1'b0);
        close_stream(1'b0);
    endtask

    // Drop valid and hold until every expected result has been received.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_checks();
        put_byte(16'h0000, 8'hFF);
        put_byte(16'hFFFF, 8'hA5);
        fetch_byte(16'hFFFF);
        // end marker with no header byte at all: clean finish
        close_stream(1'b1);
        // longword at 16 wraps to zero once the reset base is added
        put_byte(16'd16, 8'hFF);
        put_byte(16'd17, 8'hFF);
        put_byte(16'd18, 8'hF0);
        put_byte(16'd19, 8'h00);
        feed_header(32'd16);
        fetch_byte(16'd17);
        cover_patch(32'd18);
        feed(8'h02, 1'b1);
        feed(CODE_SKIP, 1'b1);
        // odd code other than the skip closes the stream with an error
        feed(8'hFF, 1'b1);
        feed(8'h55, 1'b0);
        close_stream(1'b0);
        // all-ones start is out of range; a step of two wraps it back to byte 1
        cover_patch(32'd1);
        feed_header(32'hFFFF_FFFF);
        feed(8'h02, 1'b1);
        feed(CODE_END, 1'b1);
        close_stream(1'b0);
        // last longword that fits, then the first one that does not; both truncated
        cover_patch(32'(IMAGE_BYTES - 4));
        feed_header(32'(IMAGE_BYTES - 4));
        close_stream(1'b1);
        feed_header(32'(IMAGE_BYTES - 3));
        close_stream(1'b1);
        // header cut short after three bytes
        feed(8'h12, 1'b1);
        feed(8'h34, 1'b1);
        feed(8'h56, 1'b1);
        close_stream(1'b1);
    endtask

    // One relocation stream with random content and a random ending, at times cut short in the header.
    task automatic run_stream();
        int          shape;
        logic [31:0] off;
        logic [7:0]  code;
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            repeat ($urandom_range(0, 3)) feed(8'($urandom), 1'b1);
            close_stream(1'b1);
            return;
        end
        if (shape < 14)
            off = '0;
        else if (shape < 22)
            off = 32'(IMAGE_BYTES - 6) + 32'($urandom_range(0, 5));
        else if (shape < 27)
            off = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
        else if (shape < 32)
            off = $urandom;
        else if (shape < 45)
            off = 32'($urandom_range(1, IMAGE_BYTES - 4));
        else
            off = 32'($urandom_range(1, 2047));
        if (off != 32'd0)
            cover_patch(off);
        feed_header(off);
        if (off == 32'd0) begin
            trailing_noise();
            return;
        end
        repeat ($urandom_range(0, 7)) begin
            if ($urandom_range(0, 3) == 0) begin
                code = CODE_SKIP;
                off  = off + SKIP_DISTANCE;
            end else begin
                code = {7'($urandom_range(1, 127)), 1'b0};
                off  = off + 32'(code);
                cover_patch(off);
            end
            feed(code, 1'b1);
        end
        case ($urandom_range(0, 3))
            0, 1: begin
                feed(CODE_END, 1'b1);
                trailing_noise();
            end
            2: begin
                feed({7'($urandom_range(1, 127)), 1'b1}, 1'b1);
                trailing_noise();
            end
            default: close_stream(1'b1);
        endcase
    endtask

    task automatic random_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            run_stream();
        else if (pick < 75)
            put_byte(16'($urandom), 8'($urandom));
        else if (pick < 92)
            fetch_byte(16'(written_list[$urandom_range(0, written_list.size() - 1)]));
        else
            close_stream(1'b1);
    endtask

    initial
    begin
        logic [31:0] base_value;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Run the directed transactions under the reset base.
        directed_checks();
        drain();

        // Sweep the base through its extremes, the value one and two random values; the
        // block is idle at each write. The third phase runs with no idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       base_value = 32'h0000_0000;
                1:       base_value = 32'hFFFF_FFFF;
                3:       base_value = 32'h0000_0001;
                default: base_value = $urandom;
            endcase
            if (p == 1)
                cfg_write(ADDR_UNMAPPED, $urandom);
            cfg_write(ADDR_RELOC_BASE, base_value);
            calm = (p == 2);
            item_count = 0;
            while (item_count < ITEMS_PER_PHASE)
                random_step();
            drain();
        end

        // Let any stray result show up before the verdict.
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_ram.sv
hw/rtl/rsp_patch.sv
hw/rtl/relocation_stream_patcher.sv
tb/sv/rsp_checker.sv
tb/sv/tb_relocation_stream_patcher.sv
